// File: rtl/pfdb_pkg.sv
// Shared types, format codes and the 8x8 ordered dither matrix.
`timescale 1ns / 1ps
package pfdb_pkg;

  localparam logic [1:0] FMT_32 = 2'd0;
  localparam logic [1:0] FMT_24 = 2'd1;
  localparam logic [1:0] FMT_16 = 2'd2;
  localparam logic [1:0] FMT_15 = 2'd3;

  localparam logic [2:0] COUNT_32 = 3'd4;
  localparam logic [2:0] COUNT_24 = 3'd3;
  localparam logic [2:0] COUNT_16 = 3'd2;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  localparam logic [4:0] MAX5 = 5'd31;
  localparam logic [5:0] MAX6 = 6'd63;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;

  typedef struct packed {
    logic [7:0] ch3;
    logic [7:0] ch2;
    logic [7:0] ch1;
    logic [7:0] alpha;
  } pix_t;

  typedef struct packed {
    pix_t       src;
    pix_t       dst;
    logic [2:0] x_phase;
    logic [2:0] y_phase;
    logic       blend;
  } item_t;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic [2:0]  byte_count;
    logic        write_enable;
  } result_t;

  function automatic logic [5:0] bayer8(input logic [2:0] y, input logic [2:0] x);
    logic [5:0] v;
    v = 6'd0;
    case ({y, x})
      6'd0:  v = 6'd0;   6'd1:  v = 6'd48;  6'd2:  v = 6'd12;  6'd3:  v = 6'd60;
      6'd4:  v = 6'd3;   6'd5:  v = 6'd51;  6'd6:  v = 6'd15;  6'd7:  v = 6'd63;
      6'd8:  v = 6'd32;  6'd9:  v = 6'd16;  6'd10: v = 6'd44;  6'd11: v = 6'd28;
      6'd12: v = 6'd35;  6'd13: v = 6'd19;  6'd14: v = 6'd47;  6'd15: v = 6'd31;
      6'd16: v = 6'd8;   6'd17: v = 6'd56;  6'd18: v = 6'd4;   6'd19: v = 6'd52;
      6'd20: v = 6'd11;  6'd21: v = 6'd59;  6'd22: v = 6'd7;   6'd23: v = 6'd55;
      6'd24: v = 6'd40;  6'd25: v = 6'd24;  6'd26: v = 6'd36;  6'd27: v = 6'd20;
      6'd28: v = 6'd43;  6'd29: v = 6'd27;  6'd30: v = 6'd39;  6'd31: v = 6'd23;
      6'd32: v = 6'd2;   6'd33: v = 6'd50;  6'd34: v = 6'd14;  6'd35: v = 6'd62;
      6'd36: v = 6'd1;   6'd37: v = 6'd49;  6'd38: v = 6'd13;  6'd39: v = 6'd61;
      6'd40: v = 6'd34;  6'd41: v = 6'd18;  6'd42: v = 6'd46;  6'd43: v = 6'd30;
      6'd44: v = 6'd33;  6'd45: v = 6'd17;  6'd46: v = 6'd45;  6'd47: v = 6'd29;
      6'd48: v = 6'd10;  6'd49: v = 6'd58;  6'd50: v = 6'd6;   6'd51: v = 6'd54;
      6'd52: v = 6'd9;   6'd53: v = 6'd57;  6'd54: v = 6'd5;   6'd55: v = 6'd53;
      6'd56: v = 6'd42;  6'd57: v = 6'd26;  6'd58: v = 6'd38;  6'd59: v = 6'd22;
      6'd60: v = 6'd41;  6'd61: v = 6'd25;  6'd62: v = 6'd37;  6'd63: v = 6'd21;
      default: v = 6'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/pfdb_blend.sv
// Alpha blend of three colour bytes, keeping the destination alpha.
`timescale 1ns / 1ps
module pfdb_blend (
  input  pfdb_pkg::pix_t src,
  input  pfdb_pkg::pix_t dst,
  output pfdb_pkg::pix_t mixed
);
  import pfdb_pkg::*;

  logic [7:0] inv_a;

  function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] ia,
                                     input logic [7:0] s, input logic [7:0] d);
    logic [16:0] sum;
    sum = {1'b0, 16'(a * s)} + {1'b0, 16'(ia * d)};
    return sum[15:8];
  endfunction

  assign inv_a = ALPHA_OPAQUE - src.alpha;

  assign mixed.alpha = dst.alpha;
  assign mixed.ch1   = mix(src.alpha, inv_a, src.ch1, dst.ch1);
  assign mixed.ch2   = mix(src.alpha, inv_a, src.ch2, dst.ch2);
  assign mixed.ch3   = mix(src.alpha, inv_a, src.ch3, dst.ch3);

endmodule

// File: rtl/pfdb_dither.sv
// Ordered dither, saturate and pack to 5:6:5 or 5:5:5.
`timescale 1ns / 1ps
module pfdb_dither (
  input  pfdb_pkg::pix_t src,
  input  logic [2:0]     x_phase,
  input  logic [2:0]     y_phase,
  input  logic           wide_green,
  output logic [15:0]    packed_word
);
  import pfdb_pkg::*;

  logic [5:0] dv;
  logic [4:0] c1, c3, c2_5;
  logic [5:0] c2_6;

  function automatic logic [4:0] quant5(input logic [7:0] c, input logic [5:0] d);
    logic [8:0] s;
    s = {1'b0, c} + {6'd0, d[5:3]};
    return (s[8:3] > {1'b0, MAX5}) ? MAX5 : s[7:3];
  endfunction

  function automatic logic [5:0] quant6(input logic [7:0] c, input logic [5:0] d);
    logic [8:0] s;
    s = {1'b0, c} + {5'd0, d[5:2]};
    return (s[8:2] > {1'b0, MAX6}) ? MAX6 : s[7:2];
  endfunction

  assign dv   = bayer8(y_phase, x_phase);
  assign c1   = quant5(src.ch1, dv);
  assign c3   = quant5(src.ch3, dv);
  assign c2_5 = quant5(src.ch2, dv);
  assign c2_6 = quant6(src.ch2, dv);

  assign packed_word = wide_green ? {c3, c2_6, c1} : {1'b0, c3, c2_5, c1};

endmodule

// File: rtl/pixel_format_dither_blend.sv
// Top level: input register, format datapath, result register.
//
// channel  direction  handshake                 payload
// s_axis   in         s_tvalid / s_tready       s_tdata[71:0], s_tuser (blend)
// m_axis   out        m_tvalid / m_tready       m_tdata[39:0], m_tuser (write_enable)
// cfg      in         cfg_we                    cfg_wdata[1:0] (dest_format)
//
// One word per clock sustained while m_tready stays high. The input register
// and the result register form a two-stage pipeline, so a word is taken while
// a finished result waits on m_tready, as long as the input register is empty.
// rst clears both stage valid flags and sets dest_format to 32 bpp.
`timescale 1ns / 1ps
module pixel_format_dither_blend (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // src_alpha, src_ch1, src_ch2, src_ch3, dst_alpha, dst_ch1, dst_ch2, dst_ch3,
  // x_phase, y_phase, zero fill
  input  logic [pfdb_pkg::IN_DATA_W-1:0]  s_tdata,
  // blend
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // pixel_word, byte_count, zero fill
  output logic [pfdb_pkg::OUT_DATA_W-1:0] m_tdata,
  // write_enable
  output logic                            m_tuser
);
  import pfdb_pkg::*;

  logic [1:0] dest_format;
  logic       in_valid;
  item_t      in_item;
  logic       out_valid;
  result_t    out_res;
  result_t    res_next;
  logic       adv_out;
  pix_t       mixed;
  logic [15:0] dith_word;

  assign adv_out  = !out_valid || m_tready;
  assign s_tready = !in_valid || adv_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_format <= FMT_32;
    end else if (cfg_we) begin
      dest_format <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (adv_out) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.src     <= s_tdata[31:0];
      in_item.dst     <= s_tdata[63:32];
      in_item.x_phase <= s_tdata[66:64];
      in_item.y_phase <= s_tdata[69:67];
      in_item.blend   <= s_tuser;
    end
    if (adv_out && in_valid) begin
      out_res <= res_next;
    end
  end

  pfdb_blend u_blend (
    .src   (in_item.src),
    .dst   (in_item.dst),
    .mixed (mixed)
  );

  pfdb_dither u_dither (
    .src         (in_item.src),
    .x_phase     (in_item.x_phase),
    .y_phase     (in_item.y_phase),
    .wide_green  (dest_format == FMT_16),
    .packed_word (dith_word)
  );

  always_comb begin
    res_next = '0;
    unique case (dest_format)
      FMT_32: begin
        res_next.byte_count = COUNT_32;
        if (!in_item.blend || in_item.src.alpha == ALPHA_OPAQUE) begin
          res_next.pixel_word   = in_item.src;
          res_next.write_enable = 1'b1;
        end else if (in_item.src.alpha != ALPHA_CLEAR) begin
          res_next.pixel_word   = mixed;
          res_next.write_enable = 1'b1;
        end
      end
      FMT_24: begin
        res_next.byte_count = COUNT_24;
        if (!in_item.blend) begin
          res_next.pixel_word   = {8'd0, in_item.src.ch3, in_item.src.ch2, in_item.src.ch1};
          res_next.write_enable = 1'b1;
        end
      end
      FMT_16, FMT_15: begin
        res_next.byte_count = COUNT_16;
        if (!in_item.blend) begin
          res_next.pixel_word   = {16'd0, dith_word};
          res_next.write_enable = 1'b1;
        end
      end
      default: res_next = '0;
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_res.byte_count, out_res.pixel_word};
  assign m_tuser  = out_res.write_enable;

endmodule

// File: tb/pixel_format_dither_blend_tb.sv
// Self-checking testbench for the pixel format, ordered dither and alpha blend stage.
`timescale 1ns / 1ps
module pixel_format_dither_blend_tb;
  import pfdb_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RAND_PHASES  = 9;
  localparam int PHASE_PIXELS = 188;
  localparam int HOLD_CYCLES  = 160;
  localparam int REPORT_MAX   = 10;
  localparam int DIR_ROWS     = 22;

  typedef struct packed {
    logic [7:0] sa, s1, s2, s3, da, d1, d2, d3;
    logic [2:0] xp, yp;
    logic       blend;
  } pix_req_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    logic        we;
  } pix_res_t;

  typedef struct packed {
    logic [1:0] fmt;
    pix_req_t   req;
    logic       typed;
    pix_res_t   res;
  } dir_row_t;

  localparam pix_res_t UNTYPED = '0;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{FMT_32, '{8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 3'd0, 3'd0, 1'b0},
      1'b1, '{32'h3322_1100, COUNT_32, 1'b1}},
    '{FMT_32, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7, 3'd7, 1'b0},
      1'b1, '{32'hFFFF_FFFF, COUNT_32, 1'b1}},
    '{FMT_32, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 3'd0, 1'b0},
      1'b1, '{32'h0000_0000, COUNT_32, 1'b1}},
    '{FMT_32, '{8'hFF, 8'h12, 8'h34, 8'h56, 8'h9A, 8'hBC, 8'hDE, 8'hF0, 3'd1, 3'd2, 1'b1},
      1'b1, '{32'h5634_12FF, COUNT_32, 1'b1}},
    '{FMT_32, '{8'h00, 8'hAA, 8'hBB, 8'hCC, 8'h11, 8'h22, 8'h33, 8'h44, 3'd3, 3'd4, 1'b1},
      1'b1, '{32'h0000_0000, COUNT_32, 1'b0}},
    '{FMT_32, '{8'h80, 8'hFF, 8'h00, 8'h80, 8'h5A, 8'h00, 8'hFF, 8'h40, 3'd5, 3'd6, 1'b1},
      1'b0, UNTYPED},
    '{FMT_32, '{8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 3'd7, 3'd0, 1'b1},
      1'b0, UNTYPED},
    '{FMT_32, '{8'hFE, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd2, 3'd5, 1'b1},
      1'b0, UNTYPED},
    '{FMT_24, '{8'h77, 8'hAB, 8'hCD, 8'hEF, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 3'd0, 1'b0},
      1'b1, '{32'h00EF_CDAB, COUNT_24, 1'b1}},
    '{FMT_24, '{8'h80, 8'h12, 8'h34, 8'h56, 8'hFF, 8'h01, 8'h02, 8'h03, 3'd4, 3'd1, 1'b1},
      1'b1, '{32'h0000_0000, COUNT_24, 1'b0}},
    '{FMT_24, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7, 3'd7, 1'b0},
      1'b1, '{32'h00FF_FFFF, COUNT_24, 1'b1}},
    '{FMT_16, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 3'd0, 1'b0},
      1'b1, '{32'h0000_0000, COUNT_16, 1'b1}},
    '{FMT_16, '{8'h3C, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 3'd7, 3'd0, 1'b0},
      1'b1, '{32'h0000_FFFF, COUNT_16, 1'b1}},
    '{FMT_16, '{8'hFF, 8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60, 8'h70, 3'd6, 3'd3, 1'b1},
      1'b1, '{32'h0000_0000, COUNT_16, 1'b0}},
    '{FMT_16, '{8'h00, 8'hF8, 8'hFC, 8'hF8, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 3'd0, 1'b0},
      1'b0, UNTYPED},
    '{FMT_16, '{8'h55, 8'h80, 8'h80, 8'h80, 8'hAA, 8'h11, 8'h22, 8'h33, 3'd3, 3'd5, 1'b0},
      1'b0, UNTYPED},
    '{FMT_16, '{8'hFF, 8'h07, 8'h03, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00, 3'd7, 3'd7, 1'b0},
      1'b0, UNTYPED},
    '{FMT_15, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 3'd0, 1'b0},
      1'b1, '{32'h0000_0000, COUNT_16, 1'b1}},
    '{FMT_15, '{8'hC3, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 3'd7, 3'd0, 1'b0},
      1'b1, '{32'h0000_7FFF, COUNT_16, 1'b1}},
    '{FMT_15, '{8'hFF, 8'h99, 8'h88, 8'h77, 8'h66, 8'h55, 8'h44, 8'h33, 3'd5, 3'd2, 1'b1},
      1'b1, '{32'h0000_0000, COUNT_16, 1'b0}},
    '{FMT_15, '{8'h00, 8'hF8, 8'hF8, 8'hF8, 8'h00, 8'h00, 8'h00, 8'h00, 3'd3, 3'd0, 1'b0},
      1'b0, UNTYPED},
    '{FMT_15, '{8'h21, 8'h12, 8'h34, 8'h56, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2, 3'd6, 1'b0},
      1'b0, UNTYPED}
  };

  localparam logic [1:0] PHASE_FMT [RAND_PHASES] = '{
    FMT_32, FMT_16, FMT_24, FMT_15, FMT_32, FMT_15, FMT_16, FMT_24, FMT_32
  };
  localparam int TX_RATES [3] = '{0, 15, 40};
  localparam int RX_RATES [3] = '{20, 45, 0};

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  // src_alpha, src_ch1, src_ch2, src_ch3, dst_alpha, dst_ch1, dst_ch2, dst_ch3,
  // x_phase, y_phase, zero fill
  logic [71:0] s_tdata;
  // blend
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  // pixel_word, byte_count, zero fill
  logic [39:0] m_tdata;
  // write_enable
  logic        m_tuser;

  logic [1:0]  fmt_now;
  pix_req_t    cur_px;
  logic        row_typed;
  pix_res_t    row_res;
  pix_res_t    pending_px [$];
  int          bad_px;
  int          tx_rate;
  int          rx_rate;
  logic        hold_req;

  pixel_format_dither_blend u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic logic [7:0] mix_ch(input logic [7:0] a, input logic [7:0] s,
                                        input logic [7:0] d);
    logic [16:0] acc;
    acc = 17'(a) * 17'(s) + 17'(ALPHA_OPAQUE - a) * 17'(d);
    return acc[15:8];
  endfunction

  function automatic logic [5:0] quantize(input logic [7:0] c, input logic [5:0] add,
                                          input int sh, input logic [5:0] top);
    logic [8:0] v;
    v = ({1'b0, c} + {3'b000, add}) >> sh;
    return (v > 9'(top)) ? top : v[5:0];
  endfunction

  function automatic pix_res_t format_pixel(input logic [1:0] fmt, input pix_req_t p);
    pix_res_t   r;
    logic [5:0] dv;
    logic [5:0] c1, c2, c3;
    r = '0;
    dv = {p.xp[0] ^ p.yp[0], p.xp[0], p.xp[1] ^ p.yp[1], p.xp[1],
          p.xp[2] ^ p.yp[2], p.xp[2]};
    c1 = quantize(p.s1, dv >> 3, 3, 6'(MAX5));
    c3 = quantize(p.s3, dv >> 3, 3, 6'(MAX5));
    case (fmt)
      FMT_32: begin
        r.count = COUNT_32;
        if (!p.blend || p.sa == ALPHA_OPAQUE) begin
          r.word = {p.s3, p.s2, p.s1, p.sa};
          r.we = 1'b1;
        end else if (p.sa != ALPHA_CLEAR) begin
          r.word = {mix_ch(p.sa, p.s3, p.d3), mix_ch(p.sa, p.s2, p.d2),
                    mix_ch(p.sa, p.s1, p.d1), p.da};
          r.we = 1'b1;
        end
      end
      FMT_24: begin
        r.count = COUNT_24;
        if (!p.blend) begin
          r.word = {8'h00, p.s3, p.s2, p.s1};
          r.we = 1'b1;
        end
      end
      FMT_16: begin
        r.count = COUNT_16;
        c2 = quantize(p.s2, dv >> 2, 2, MAX6);
        if (!p.blend) begin
          r.word = {16'h0000, c3[4:0], c2, c1[4:0]};
          r.we = 1'b1;
        end
      end
      default: begin
        r.count = COUNT_16;
        c2 = quantize(p.s2, dv >> 3, 3, 6'(MAX5));
        if (!p.blend) begin
          r.word = {17'h00000, c3[4:0], c2[4:0], c1[4:0]};
          r.we = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    pix_res_t got;
    pix_res_t want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        pending_px.push_back(row_typed ? row_res : format_pixel(fmt_now, cur_px));
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[31:0], m_tdata[34:32], m_tuser};
        if (pending_px.size() == 0) begin
          bad_px++;
          if (bad_px <= REPORT_MAX)
            $display("%0t: unexpected word %h count %0d we %b", $realtime,
                     got.word, got.count, got.we);
        end else begin
          want = pending_px.pop_front();
          if (got !== want || m_tdata[39:35] !== 5'b00000) begin
            bad_px++;
            if (bad_px <= REPORT_MAX)
              $display("%0t: expected word %h count %0d we %b, got %h %0d %b fill %b",
                       $realtime, want.word, want.count, want.we,
                       got.word, got.count, got.we, m_tdata[39:35]);
          end
        end
      end
    end
  end

  initial begin
    int rx_burst;
    rx_burst = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (rx_burst > 0) begin
        m_tready = 1'b0;
        rx_burst--;
      end else if (rx_rate != 0 && $urandom_range(99) < rx_rate) begin
        m_tready = 1'b0;
        rx_burst = $urandom_range(8, 1) - 1;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  task automatic wait_drained();
    while (pending_px.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_format(input logic [1:0] f);
    s_tvalid = 1'b0;
    wait_drained();
    cfg_wdata = f;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    fmt_now = f;
  endtask

  task automatic send_px(input pix_req_t p, input logic typed, input pix_res_t res);
    if (tx_rate != 0 && $urandom_range(99) < tx_rate) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(8, 1)) @(negedge clk);
    end
    cur_px = p;
    row_typed = typed;
    row_res = res;
    s_tdata = {2'b00, p.yp, p.xp, p.d3, p.d2, p.d1, p.da, p.s3, p.s2, p.s1, p.sa};
    s_tuser = p.blend;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  initial begin
    pix_req_t p;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = FMT_32;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    fmt_now = FMT_32;
    cur_px = '0;
    row_typed = 1'b0;
    row_res = '0;
    bad_px = 0;
    tx_rate = 0;
    rx_rate = 0;
    hold_req = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].fmt != fmt_now)
        set_format(DIR_TAB[i].fmt);
      send_px(DIR_TAB[i].req, DIR_TAB[i].typed, DIR_TAB[i].res);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_format(PHASE_FMT[ph]);
      tx_rate = (ph == RAND_PHASES - 1) ? 0 : TX_RATES[ph % 3];
      rx_rate = (ph == RAND_PHASES - 1) ? 0 : RX_RATES[ph % 3];
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        // stall the output while input keeps coming
        if (ph == 3 && k == 40)
          hold_req = 1'b1;
        // hold input until the pipe drains
        if (ph == 5 && k == 90) begin
          s_tvalid = 1'b0;
          wait_drained();
        end
        p.sa = pick_byte();
        p.s1 = pick_byte();
        p.s2 = pick_byte();
        p.s3 = pick_byte();
        p.da = 8'($urandom);
        p.d1 = pick_byte();
        p.d2 = pick_byte();
        p.d3 = pick_byte();
        p.xp = 3'($urandom);
        p.yp = 3'($urandom);
        p.blend = ($urandom_range(99) < 40);
        send_px(p, 1'b0, UNTYPED);
      end
    end

    s_tvalid = 1'b0;
    wait_drained();
    if (bad_px == 0)
      $display("pixel_format_dither_blend regression: pass");
    else
      $display("pixel_format_dither_blend regression: fail");
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("pixel_format_dither_blend regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
rtl/pfdb_pkg.sv
rtl/pfdb_blend.sv
rtl/pfdb_dither.sv
rtl/pixel_format_dither_blend.sv
tb/pixel_format_dither_blend_tb.sv
